@@ rtl/dctf_pkg.sv @@
// Shared constants, types and cosine table for the 8x8 forward DCT block.
package dctf_pkg;

  localparam int BLOCK_SIZE     = 8;
  localparam int LOG2N          = 3;
  localparam int NPIX           = BLOCK_SIZE * BLOCK_SIZE;
  localparam int ADDR_W         = 2 * LOG2N;
  localparam int COEF_FRAC_BITS = 8;
  localparam int PIX_W          = 8;
  localparam int COS_W          = 16;
  localparam int ROW_W          = 26;
  localparam int PROD_W         = 43;
  localparam int ACC_W          = 46;
  localparam int COEF_W         = 18;
  localparam int LEVEL_W        = 8;
  localparam int GAIN_W         = 10;
  localparam int STEP_W         = 4;
  localparam int QSHIFT         = 28 - COEF_FRAC_BITS + 2 * LOG2N - 2;

  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 10'd10;
  localparam logic [COEF_W:0]    COEF_MAG_MAX  = 19'd131072;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 8'd255;
  localparam logic [27:0]        LEVEL_LIMIT   = 28'd65024;
  localparam logic [STEP_W-1:0]  STEP_ROW_END  = 4'd10;
  localparam logic [STEP_W-1:0]  STEP_COEF     = 4'd10;
  localparam logic [STEP_W-1:0]  STEP_COL_END  = 4'd11;

  // one result leaving the core
  typedef struct packed {
    logic                      valid;
    logic signed [COEF_W-1:0]  coefficient;
    logic [LEVEL_W-1:0]        display_level;
    logic [2:0]                row_freq;
    logic [2:0]                col_freq;
    logic                      last;
  } dctf_emit_t;

  // cos(m*pi/16) in Q1.14 for 0 <= m <= 8
  function automatic logic signed [COS_W-1:0] quarter_cos(input logic [4:0] m);
    logic signed [COS_W-1:0] c;
    begin
      case (m)
        5'd0:    c = 16'sd16384;
        5'd1:    c = 16'sd16069;
        5'd2:    c = 16'sd15137;
        5'd3:    c = 16'sd13623;
        5'd4:    c = 16'sd11585;
        5'd5:    c = 16'sd9102;
        5'd6:    c = 16'sd6270;
        5'd7:    c = 16'sd3196;
        default: c = 16'sd0;
      endcase
      return c;
    end
  endfunction

  // basis value cos((2*pos+1)*freq*pi/16)
  function automatic logic signed [COS_W-1:0] basis(input logic [2:0] pos,
                                                   input logic [2:0] freq);
    logic [6:0] prod;
    logic [4:0] m;
    logic signed [COS_W-1:0] c;
    begin
      prod = ({3'd0, pos, 1'b1}) * {4'd0, freq};
      m    = prod[4:0];
      if (m <= 5'd8)       c = quarter_cos(m);
      else if (m <= 5'd16) c = -quarter_cos(5'd16 - m);
      else if (m <= 5'd24) c = -quarter_cos(m - 5'd16);
      else                 c = quarter_cos(5'd0 - m);
      return c;
    end
  endfunction

endpackage

@@ rtl/dctf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module dctf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dctf_core.sv @@
// Row-column DCT engine: pixel and row-transform memories around one shared MAC.
module dctf_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pix_we,
  input  logic [dctf_pkg::ADDR_W-1:0] pix_waddr,
  input  logic [dctf_pkg::PIX_W-1:0]  pix_wdata,
  input  logic                        start,
  input  logic [dctf_pkg::GAIN_W-1:0] gain,
  input  logic                        slot_free,
  output logic                        busy,
  output dctf_pkg::dctf_emit_t        emit
);
  import dctf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROW  = 3'b010,
    ST_COL  = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [ADDR_W-1:0]        oidx_r, oidx_nxt;
  logic                     v1_r, v2_r, first1_r, first2_r;
  logic [2:0]               k1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [COEF_W-1:0] coef_r;
  logic [COEF_W-1:0]        umag_r;

  logic                     issue, advance;
  logic [2:0]               k, freq;
  logic [ADDR_W-1:0]        pix_raddr, row_raddr;
  logic [PIX_W-1:0]         pix_rdata;
  logic [ROW_W-1:0]         row_rdata;
  logic                     row_we;
  logic signed [ROW_W:0]    operand;
  logic signed [COS_W-1:0]  cosv;

  dctf_ram #(.DEPTH(NPIX), .WIDTH(PIX_W)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  dctf_ram #(.DEPTH(NPIX), .WIDTH(ROW_W)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (oidx_r),
    .wdata (acc_r[ROW_W-1:0]),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // read addresses: row pass walks x of row y, column pass walks y of column u
  assign issue     = (state_r != ST_IDLE) && !step_r[STEP_W-1];
  assign k         = step_r[2:0];
  assign pix_raddr = {oidx_r[5:3], k};
  assign row_raddr = {k, oidx_r[2:0]};
  assign freq      = (state_r == ST_ROW) ? oidx_r[2:0] : oidx_r[5:3];
  assign row_we    = (state_r == ST_ROW) && (step_r == STEP_ROW_END);
  assign busy      = (state_r != ST_IDLE);

  // multiplier operand select
  always_comb begin
    if (state_r == ST_ROW) begin
      operand = signed'({{(ROW_W + 1 - PIX_W){1'b0}}, pix_rdata});
    end else begin
      operand = signed'({row_rdata[ROW_W-1], row_rdata});
    end
    cosv = basis(k1_r, freq);
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r     <= k;
    first1_r <= (k == 3'd0);
    first2_r <= first1_r;
    prod_r   <= PROD_W'(operand * cosv);
    if (v2_r) begin
      acc_r <= first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // round the column sum to the coefficient and saturate
  logic [ACC_W-1:0] amag;
  logic [ACC_W:0]   rsum;
  logic [ACC_W:0]   q;
  logic [1:0]       sh;
  logic [COEF_W:0]  qs;
  logic [COEF_W-1:0] umag;
  logic signed [COEF_W-1:0] coef;

  always_comb begin
    amag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    sh   = {1'b0, oidx_r[2:0] == 3'd0} + {1'b0, oidx_r[5:3] == 3'd0};
    case (sh)
      2'd0:    begin
        rsum = {1'b0, amag} + ((ACC_W + 1)'(1) << (QSHIFT - 1));
        q    = rsum >> QSHIFT;
      end
      2'd1:    begin
        rsum = {1'b0, amag} + ((ACC_W + 1)'(1) << QSHIFT);
        q    = rsum >> (QSHIFT + 1);
      end
      default: begin
        rsum = {1'b0, amag} + ((ACC_W + 1)'(1) << (QSHIFT + 1));
        q    = rsum >> (QSHIFT + 2);
      end
    endcase
    qs = (q > (ACC_W + 1)'(COEF_MAG_MAX)) ? COEF_MAG_MAX : q[COEF_W:0];
    if (acc_r[ACC_W-1]) begin
      coef = COEF_W'(-qs);
      umag = (qs == COEF_MAG_MAX) ? COEF_MAG_MAX[COEF_W-1:0] : qs[COEF_W-1:0];
    end else begin
      umag = (qs == COEF_MAG_MAX) ? COEF_W'(COEF_MAG_MAX - 1'b1) : qs[COEF_W-1:0];
      coef = signed'(umag);
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_COL) && (step_r == STEP_COEF)) begin
      coef_r <= coef;
      umag_r <= umag;
    end
  end

  // display level from the rounded magnitude
  logic [27:0]        lprod;
  logic [27:0]        lsum;
  logic [LEVEL_W-1:0] level;

  always_comb begin
    lprod = 28'(umag_r) * 28'(gain);
    lsum  = lprod + 28'd128;
    level = (lprod > LEVEL_LIMIT) ? LEVEL_MAX : lsum[15:8];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    oidx_nxt  = oidx_r;
    advance   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ROW;
          step_nxt  = '0;
          oidx_nxt  = '0;
        end
      end
      ST_ROW: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_ROW_END) begin
          step_nxt = '0;
          oidx_nxt = oidx_r + 1'b1;
          if (oidx_r == ADDR_W'(NPIX - 1)) begin
            state_nxt = ST_COL;
          end
        end
      end
      ST_COL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_COL_END) begin
          step_nxt = step_r;
          if (slot_free) begin
            advance  = 1'b1;
            step_nxt = '0;
            oidx_nxt = oidx_r + 1'b1;
            if (oidx_r == ADDR_W'(NPIX - 1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // result toward the output register
  always_comb begin
    emit.valid         = advance;
    emit.coefficient   = coef_r;
    emit.display_level = level;
    emit.row_freq      = oidx_r[5:3];
    emit.col_freq      = oidx_r[2:0];
    emit.last          = (oidx_r == ADDR_W'(NPIX - 1));
  end

  a_emit_col: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> (state_r == ST_COL) && (step_r == STEP_COL_END))
    else $error("result emitted outside column pass end step");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> (step_r <= STEP_ROW_END))
    else $error("row pass step out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last) |=> (state_r == ST_IDLE))
    else $error("engine not idle after last coefficient");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !pix_we)
    else $error("pixel written while transform runs");

endmodule

@@ rtl/dct_8x8_forward_top.sv @@
// Top level of the 8x8 forward DCT: stream ports, gain register, pixel load, output register.
// Each block is loaded, then transformed as 64 row terms (8 memory reads each, then the
// multiply and accumulate stages drain) and 64 column terms (with a final step to emit,
// which waits while the output register is full) on the one shared multiplier.
// Pixels are taken only while the engine is idle; the output register lets loading resume
// while the last coefficient waits. Reset (rst_n low, synchronous) clears the load count,
// the output valid and the engine state, and sets display_gain to 10.
module dct_8x8_forward_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [dctf_pkg::GAIN_W-1:0] cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // pixel[7:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // coefficient, display_level, row_freq, col_freq
  output logic                        out_tlast
);
  import dctf_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [ADDR_W-1:0] load_count_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;
  logic              out_last_r;
  logic              busy, in_acc, slot_free;
  dctf_emit_t        emit;

  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  dctf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_we    (in_acc),
    .pix_waddr (load_count_r),
    .pix_wdata (in_tdata),
    .start     (in_acc && (load_count_r == ADDR_W'(NPIX - 1))),
    .gain      (gain_r),
    .slot_free (slot_free),
    .busy      (busy),
    .emit      (emit)
  );

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // count pixels of the current block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else if (in_acc) begin
      load_count_r <= load_count_r + 1'b1;
    end
  end

  // output register: load on emit, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data_r <= {emit.col_freq, emit.row_freq, emit.display_level, emit.coefficient};
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
